/* design/hourglass_window_max_sum_assert.svh */
// ---------------------------------------------------------------------------
// hourglass_window_max_sum_assert.svh
// Assertion macros for the hourglass window max-sum block. Each macro
// samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HOURGLASS_WINDOW_MAX_SUM_ASSERT_SVH
`define HOURGLASS_WINDOW_MAX_SUM_ASSERT_SVH

// same-cycle implication
`define HWMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hwms_pkg.sv */
// ---------------------------------------------------------------------------
// hwms_pkg
// Shared sizes, types and helpers for the hourglass window max-sum block.
// ---------------------------------------------------------------------------
package hwms_pkg;

  // grid geometry and cell width
  localparam int GRID_SIDE = 6;
  localparam int CELL_BITS = 8;
  localparam int COL_BITS  = $clog2(GRID_SIDE);

  // seven signed cells need three extra bits at full precision
  localparam int SUM_BITS  = CELL_BITS + 3;
  localparam int OUT_BITS  = 11;

  // stream word widths, padded to whole bytes
  localparam int IN_TDATA_BITS  = ((CELL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // line buffer entry: {row r-2, row r-1}
  localparam int LINE_BITS = 2 * CELL_BITS;

  typedef logic signed [CELL_BITS-1:0] cell_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [OUT_BITS-1:0]  result_t;
  typedef logic [COL_BITS-1:0]         idx_t;

  // per-stage control that rides along with each word
  typedef struct packed {
    logic valid;  // stage holds a word
    logic win;    // word completes a 3x3 window
    logic last;   // word is the last cell of the grid
  } stage_ctl_t;

  // wrap a full-precision sum to the result width
  function automatic result_t wrap_result(sum_t s);
    wrap_result = OUT_BITS'(s);
  endfunction

endpackage

/* design/hwms_ram.sv */
// ---------------------------------------------------------------------------
// hwms_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// A read and write of the same address in one cycle returns the old data.
// ---------------------------------------------------------------------------
module hwms_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/hwms_window.sv */
// ---------------------------------------------------------------------------
// hwms_window
// 3x3 window shift register fed one column per word from the line buffer,
// followed by the registered seven-term hourglass adder.
// ---------------------------------------------------------------------------
module hwms_window
  import hwms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,       // whole pipeline steps this cycle
  input  stage_ctl_t col_ctl_i,   // control of the word carrying the column
  input  cell_t      older_i,     // row r-2 at this column
  input  cell_t      newer_i,     // row r-1 at this column
  input  cell_t      cell_i,      // current row
  output stage_ctl_t sum_ctl_o,   // control of the word carrying sum_o
  output sum_t       sum_o
);

  cell_t      win_r [3][3];       // [row][col], row 0 is the oldest
  stage_ctl_t win_ctl_r;
  stage_ctl_t sum_ctl_r;
  sum_t       sum_r;
  sum_t       sum_nxt;

  // window shift: drop the left column, bring in the new one at the right
  always_ff @(posedge clk) begin
    if (adv_i && col_ctl_i.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= older_i;
      win_r[1][2] <= newer_i;
      win_r[2][2] <= cell_i;
    end
  end

  // hourglass: top row, center, bottom row
  always_comb begin
    sum_nxt = SUM_BITS'(win_r[0][0]) + SUM_BITS'(win_r[0][1]) + SUM_BITS'(win_r[0][2])
            + SUM_BITS'(win_r[1][1])
            + SUM_BITS'(win_r[2][0]) + SUM_BITS'(win_r[2][1]) + SUM_BITS'(win_r[2][2]);
  end

  // stage control and sum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_ctl_r <= '0;
      sum_ctl_r <= '0;
    end else if (adv_i) begin
      win_ctl_r <= col_ctl_i;
      sum_ctl_r <= win_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_ctl_o = sum_ctl_r;
  assign sum_o     = sum_r;

endmodule

/* design/hwms_max_track.sv */
// ---------------------------------------------------------------------------
// hwms_max_track
// Running maximum of the hourglass sums of one grid, and the result
// register that presents the maximum on the master side.
// ---------------------------------------------------------------------------
module hwms_max_track
  import hwms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,
  input  stage_ctl_t sum_ctl_i,
  input  sum_t       sum_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output result_t    out_data_o,
  output logic       hold_o       // grid result blocked by an untaken word
);

  sum_t    best_r;
  sum_t    best_nxt;
  logic    seen_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_data_r;
  logic    take;
  logic    finish;

  // a new result needs the output register free or emptying now
  assign hold_o = sum_ctl_i.valid && sum_ctl_i.last && out_valid_r && !out_ready_i;

  assign take   = adv_i && sum_ctl_i.valid && sum_ctl_i.win;
  assign finish = take && sum_ctl_i.last;

  // compare against the running best; first window of a grid always wins
  always_comb begin
    best_nxt = best_r;
    if (!seen_r || (sum_i > best_r)) begin
      best_nxt = sum_i;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready_i;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  // running best, cleared at grid end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        best_r <= '0;
        seen_r <= 1'b0;
      end else if (take) begin
        best_r <= best_nxt;
        seen_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= wrap_result(best_nxt);
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

/* design/hourglass_window_max_sum.sv */
// ---------------------------------------------------------------------------
// hourglass_window_max_sum
// Streams a square grid of signed cells in row-major order and returns
// the largest hourglass sum of each grid.
// ---------------------------------------------------------------------------
// One cell is taken per clock. The two rows above the current one sit in a
// single line-buffer RAM (one entry per column, both rows side by side), read
// when a cell is taken and written back from stage 1, so the one read and
// one write port of that RAM set the rate of one cell per cycle. A column
// entry is read again only a full row later, well after its write-back. The
// maximum of a grid reaches the master side through the stage 1, window, sum
// and result registers; intake stalls only while that result meets an
// earlier result word not yet taken. There are no configuration registers,
// and the block restarts on a new grid right after the last cell.
// ---------------------------------------------------------------------------
`include "hourglass_window_max_sum_assert.svh"

module hourglass_window_max_sum
  import hwms_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // slave side
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [7:0] cell_value
  // master side
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata   // [10:0] max_hourglass_sum
);

  idx_t       col_r;
  idx_t       col_nxt;
  idx_t       row_r;
  idx_t       row_nxt;
  logic       col_last;
  logic       row_last;
  logic       in_accept;
  logic       adv;
  logic       hold;
  stage_ctl_t in_ctl;
  stage_ctl_t s1_ctl_r;
  cell_t      s1_cell_r;
  idx_t       s1_col_r;
  logic       lb_wr_en;
  logic [LINE_BITS-1:0] lb_rd_data;
  cell_t      lb_older;
  cell_t      lb_newer;
  stage_ctl_t sum_ctl;
  sum_t       sum;
  result_t    out_data;

  // pipeline steps unless a grid result is blocked at the output
  assign adv       = !hold;
  assign in_tready = adv;
  assign in_accept = in_tvalid && in_tready;

  // raster position of the incoming word
  assign col_last = (col_r == COL_BITS'(GRID_SIDE - 1));
  assign row_last = (row_r == COL_BITS'(GRID_SIDE - 1));

  assign in_ctl.valid = in_accept;
  assign in_ctl.win   = (row_r >= COL_BITS'(2)) && (col_r >= COL_BITS'(2));
  assign in_ctl.last  = col_last && row_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_ctl_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) begin
        s1_ctl_r <= in_ctl;
      end
    end
  end

  // stage 1 payload: waits beside the line-buffer read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r <= in_tdata[CELL_BITS-1:0];
      s1_col_r  <= col_r;
    end
  end

  // line buffer: read at intake, write back {row r-1, current} in stage 1
  assign lb_wr_en = adv && s1_ctl_r.valid;

  hwms_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (GRID_SIDE)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (lb_wr_en),
    .wr_addr (s1_col_r),
    .wr_data ({lb_newer, s1_cell_r}),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (lb_rd_data)
  );

  assign lb_older = lb_rd_data[LINE_BITS-1:CELL_BITS];
  assign lb_newer = lb_rd_data[CELL_BITS-1:0];

  // window and hourglass adder
  hwms_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .col_ctl_i (s1_ctl_r),
    .older_i   (lb_older),
    .newer_i   (lb_newer),
    .cell_i    (s1_cell_r),
    .sum_ctl_o (sum_ctl),
    .sum_o     (sum)
  );

  // running maximum and result register
  hwms_max_track u_max (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (adv),
    .sum_ctl_i   (sum_ctl),
    .sum_i       (sum),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .out_data_o  (out_data),
    .hold_o      (hold)
  );

  assign out_tdata = OUT_TDATA_BITS'($unsigned(out_data));

  // checks
  `HWMS_ASSERT_NOW(a_col_range, 1'b1, col_r <= COL_BITS'(GRID_SIDE - 1), "column out of range")
  `HWMS_ASSERT_NOW(a_last_is_window, s1_ctl_r.valid && s1_ctl_r.last, s1_ctl_r.win,
    "last cell does not complete a window")
  `HWMS_ASSERT_NOW(a_lb_no_collision, lb_wr_en && in_accept, s1_col_r != col_r,
    "line buffer read and write hit the same column")
  `HWMS_ASSERT_NEXT(a_grid_wrap, in_accept && in_ctl.last, (col_r == '0) && (row_r == '0),
    "raster position did not wrap at grid end")

endmodule

/* sim/hourglass_window_max_sum_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hourglass_window_max_sum_tb
// Streams whole 6x6 grids of signed cells into the block and checks every
// grid maximum it returns against a cycle-free predictor of the line
// buffers, the sliding 3x3 window and the running maximum. Both sides idle
// at random. The receiver also holds off once for a long stretch so that
// the block backs up, and the sender drains the block between some grids.
// ---------------------------------------------------------------------------
module hourglass_window_max_sum_tb;
  import hwms_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_GRIDS = 46;
  localparam int IDLE_PCT     = 36;

  // how the cells of one grid are chosen
  typedef enum int {
    FILL_MIN,
    FILL_MAX,
    FILL_ANY,
    FILL_EXTREME,
    FILL_SMALL,
    FILL_LOW,
    FILL_SPIKY
  } fill_mode_e;

  // Predicts each grid maximum from the accepted cells and holds the
  // maxima still owed by the block.
  class hourglass_max_tracker;
    cell_t   row_up2 [GRID_SIDE];
    cell_t   row_up1 [GRID_SIDE];
    cell_t   win [9];
    int      col;
    int      row;
    int      best;
    bit      seen;
    result_t max_q [$];
    int      fails;
    int      compared;

    function new();
      foreach (row_up2[i]) row_up2[i] = '0;
      foreach (row_up1[i]) row_up1[i] = '0;
      foreach (win[i]) win[i] = '0;
      col      = 0;
      row      = 0;
      best     = 0;
      seen     = 1'b0;
      fails    = 0;
      compared = 0;
    endfunction

    // one accepted cell: shift the window, update line buffers and maximum
    function void take_cell(cell_t v);
      int s;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = row_up2[col];
      win[5] = row_up1[col];
      win[8] = v;
      row_up2[col] = row_up1[col];
      row_up1[col] = v;

      if (row >= 2 && col >= 2) begin
        s = int'(win[0]) + int'(win[1]) + int'(win[2]) + int'(win[4])
          + int'(win[6]) + int'(win[7]) + int'(win[8]);
        if (!seen || s > best) begin
          best = s;
          seen = 1'b1;
        end
      end

      // raster position; last cell of the grid owes a result
      if (col == GRID_SIDE - 1) begin
        col = 0;
        if (row == GRID_SIDE - 1) begin
          max_q.insert(max_q.size(), result_t'(best));
          row  = 0;
          best = 0;
          seen = 1'b0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    // one accepted result word against the oldest owed maximum
    function void compare_max(logic [OUT_TDATA_BITS-1:0] word);
      logic [OUT_TDATA_BITS-1:0] want;
      result_t                   exp_max;
      if (max_q.size() == 0) begin
        $display("%0t: result word 0x%h with no maximum owed", $time, word);
        fails++;
        return;
      end
      exp_max = max_q.pop_front();
      want = '0;
      want[OUT_BITS-1:0] = exp_max;
      compared++;
      if (word !== want) begin
        $display("%0t: max_hourglass_sum expected %0d (0x%h) actual %0d (0x%h)",
                 $time, exp_max, want, result_t'(word[OUT_BITS-1:0]), word);
        fails++;
      end
    endfunction

    function int pending();
      return max_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [7:0] cell_value
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [10:0] max_hourglass_sum

  hourglass_max_tracker tracker = new();

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;
  int cells_sent  = 0;
  int grids_sent  = 0;
  int held_cycles = 0;
  int drains      = 0;

  hourglass_window_max_sum i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("hourglass_window_max_sum: mismatch");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.compare_max(out_tdata);
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
          held_cycles++;
        end
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  function automatic cell_t pick_cell(fill_mode_e mode);
    unique case (mode)
      FILL_MIN:     pick_cell = cell_t'(-128);
      FILL_MAX:     pick_cell = cell_t'(127);
      FILL_EXTREME: pick_cell = $urandom_range(1) ? cell_t'(127) : cell_t'(-128);
      FILL_SMALL:   pick_cell = cell_t'(int'($urandom_range(8)) - 4);
      FILL_LOW:     pick_cell = cell_t'(-128 + int'($urandom_range(70)));
      FILL_SPIKY: begin
        if ($urandom_range(7) == 0)
          pick_cell = $urandom_range(1) ? cell_t'(127) : cell_t'(-128);
        else
          pick_cell = cell_t'($urandom_range(255));
      end
      default:      pick_cell = cell_t'($urandom_range(255));
    endcase
  endfunction

  // offer one cell word, with random idle cycles ahead of it
  task automatic send_cell(cell_t v);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_cell(v);
    cells_sent++;
  endtask

  task automatic send_grid(fill_mode_e mode);
    for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) send_cell(pick_cell(mode));
    grids_sent++;
  endtask

  // stop offering until every owed maximum has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    drains++;
  endtask

  // stimulus
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every sum negative, then every sum at its top
    send_grid(FILL_MIN);
    send_grid(FILL_MAX);

    for (int g = 0; g < RANDOM_GRIDS; g++) begin
      no_idle = (g >= 4 && g < 10);
      if (g == 14) hold_req = 1'b1;
      if (g == 26 || g == 40) drain_results();
      send_grid(fill_mode_e'($urandom_range(FILL_SPIKY, FILL_ANY)));
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    // wait out the owed maxima, then the pipeline tail
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d cells in %0d grids sent, %0d grid maxima compared",
             cells_sent, grids_sent, tracker.compared);
    $display("receiver held off %0d cycles, sender drained the block %0d times",
             held_cycles, drains);
    if (tracker.fails == 0) begin
      $display("hourglass_window_max_sum: match");
    end else begin
      $display("hourglass_window_max_sum: mismatch");
    end
    $finish;
  end

endmodule
